@@ rtl/spu_pkg.sv @@
// Shared types and constants for the stress pair update engine.
// Used by spu_ctrl, spu_dp and the top level sgd_stress_pair_update.
package spu_pkg;

  localparam int DefMaxPoints = 1024;

  localparam int IdxW    = 10;
  localparam int InDataW = 152;
  localparam int OutDataW = 80;
  localparam int CntW    = 6;

  localparam logic [CntW-1:0] SqrtIters = CntW'(32);
  localparam logic [CntW-1:0] DivIters  = CntW'(63);

  localparam logic [31:0] StepRateReset = 32'd16777;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_PAIR  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } spu_act_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WR_IN,
    OP_RD_I,
    OP_RD_J,
    OP_CAP_J,
    OP_OUT,
    OP_DIFF,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_SUM,
    OP_SQRT,
    OP_MUL_SW,
    OP_MU,
    OP_MUL_NUM,
    OP_DIV_INIT,
    OP_DIV,
    OP_MUL_RXL,
    OP_MUL_RXH,
    OP_MUL_RYL,
    OP_MUL_RYH,
    OP_MVY,
    OP_WR_I,
    OP_WR_J
  } spu_op_e;

  typedef struct packed {
    spu_op_e op;
  } spu_cmd_t;

  typedef struct packed {
    spu_act_e action;
    logic     i_ok;
    logic     j_ok;
    logic     len_zero;
    logic     out_free;
  } spu_sts_t;

endpackage

@@ rtl/spu_ctrl.sv @@
// Sequencer of the stress pair update engine: walks each item through the
// datapath steps. Depends on spu_pkg.
module spu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spu_pkg::spu_sts_t sts_i,
  output spu_pkg::spu_cmd_t cmd_o
);
  import spu_pkg::*;

  typedef enum logic [25:0] {
    ST_IDLE = 26'd1 << 0,
    ST_DEC  = 26'd1 << 1,
    ST_WRIN = 26'd1 << 2,
    ST_RDP  = 26'd1 << 3,
    ST_RDO  = 26'd1 << 4,
    ST_RDI  = 26'd1 << 5,
    ST_RDJ  = 26'd1 << 6,
    ST_CAPJ = 26'd1 << 7,
    ST_DIFF = 26'd1 << 8,
    ST_MXX  = 26'd1 << 9,
    ST_MYY  = 26'd1 << 10,
    ST_SUM  = 26'd1 << 11,
    ST_SQRT = 26'd1 << 12,
    ST_CHK  = 26'd1 << 13,
    ST_MSW  = 26'd1 << 14,
    ST_MU   = 26'd1 << 15,
    ST_NUM  = 26'd1 << 16,
    ST_DIVI = 26'd1 << 17,
    ST_DIV  = 26'd1 << 18,
    ST_RXL  = 26'd1 << 19,
    ST_RXH  = 26'd1 << 20,
    ST_RYL  = 26'd1 << 21,
    ST_RYH  = 26'd1 << 22,
    ST_MVY  = 26'd1 << 23,
    ST_WRI  = 26'd1 << 24,
    ST_WRJ  = 26'd1 << 25
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DEC;
        end
      end
      ST_DEC: begin
        case (sts_i.action)
          ACT_WRITE: state_d = sts_i.i_ok ? ST_WRIN : ST_IDLE;
          ACT_PAIR:  state_d = (sts_i.i_ok && sts_i.j_ok) ? ST_RDI : ST_IDLE;
          ACT_READ:  state_d = ST_RDP;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_WRIN: begin
        cmd_o.op = OP_WR_IN;
        state_d  = ST_IDLE;
      end
      ST_RDP: begin
        cmd_o.op = OP_RD_I;
        state_d  = ST_RDO;
      end
      ST_RDO: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      ST_RDI: begin
        cmd_o.op = OP_RD_I;
        state_d  = ST_RDJ;
      end
      ST_RDJ: begin
        cmd_o.op = OP_RD_J;
        state_d  = ST_CAPJ;
      end
      ST_CAPJ: begin
        cmd_o.op = OP_CAP_J;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_MXX;
      end
      ST_MXX: begin
        cmd_o.op = OP_MUL_XX;
        state_d  = ST_MYY;
      end
      ST_MYY: begin
        cmd_o.op = OP_MUL_YY;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        cnt_d    = SqrtIters;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (cnt_q == '0) begin
          state_d = ST_CHK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_CHK: begin
        state_d = sts_i.len_zero ? ST_IDLE : ST_MSW;
      end
      ST_MSW: begin
        cmd_o.op = OP_MUL_SW;
        state_d  = ST_MU;
      end
      ST_MU: begin
        cmd_o.op = OP_MU;
        state_d  = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.op = OP_MUL_NUM;
        state_d  = ST_DIVI;
      end
      ST_DIVI: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = DivIters;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == '0) begin
          state_d = ST_RXL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_RXL: begin
        cmd_o.op = OP_MUL_RXL;
        state_d  = ST_RXH;
      end
      ST_RXH: begin
        cmd_o.op = OP_MUL_RXH;
        state_d  = ST_RYL;
      end
      ST_RYL: begin
        cmd_o.op = OP_MUL_RYL;
        state_d  = ST_RYH;
      end
      ST_RYH: begin
        cmd_o.op = OP_MUL_RYH;
        state_d  = ST_MVY;
      end
      ST_MVY: begin
        cmd_o.op = OP_MVY;
        state_d  = ST_WRI;
      end
      ST_WRI: begin
        cmd_o.op = OP_WR_I;
        state_d  = ST_WRJ;
      end
      ST_WRJ: begin
        cmd_o.op = OP_WR_J;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/spu_dp.sv @@
// Datapath of the stress pair update engine: point memory, shared multiplier,
// bit-serial square root and divider, saturation and output register. Uses spu_pkg.
module spu_dp #(
  parameter int MAX_POINTS = spu_pkg::DefMaxPoints
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spu_pkg::spu_cmd_t            cmd_i,
  output spu_pkg::spu_sts_t            sts_o,
  input  logic [31:0]                  step_rate_i,
  input  logic [spu_pkg::InDataW-1:0]  in_data_i,
  input  logic [1:0]                   in_user_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [spu_pkg::OutDataW-1:0] out_data_o
);
  import spu_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [30:0] OneQ30  = 31'd1 << 30;
  localparam logic [65:0] MoveCap = 66'd1 << 34;

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor((hi * 2^32 + lo) / 2^30), capped at 2^34
  function automatic logic [34:0] move_cap(input logic [63:0] hi, input logic [63:0] lo);
    logic [95:0] p;
    logic [34:0] r;
    p = {hi, 32'h0} + {32'h0, lo};
    if (p[95:30] > MoveCap) begin
      r = MoveCap[34:0];
    end else begin
      r = p[64:30];
    end
    return r;
  endfunction

  logic [63:0] mem [MAX_POINTS];
  logic [63:0] rdata_q;

  spu_act_e    act_q;
  logic [IdxW-1:0] ii_q, jj_q;
  logic [31:0] w_q, t_q, xin_q, yin_q;
  logic [31:0] xi_q, yi_q, xj_q, yj_q;
  logic [31:0] ax_q, ay_q;
  logic        dxn_q, dyn_q;
  logic [63:0] sx_q;
  logic [65:0] rad_q;
  logic [35:0] sq_rem_q;
  logic [32:0] root_q;
  logic        rneg_q;
  logic [33:0] dmag_q;
  logic [30:0] mu_q;
  logic [63:0] dvd_q;
  logic [33:0] drem_q, dvs_q;
  logic [63:0] lo_q;
  logic [34:0] mx_q, my_q;
  logic [67:0] prod_q;
  logic        out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [AW-1:0] addr_i, addr_j;
  logic          i_ok, j_ok;
  logic          mul_en;
  logic [33:0]   mul_a, mul_b;

  logic signed [35:0] vx, vy;
  logic [31:0] wr_xi, wr_yi, wr_xj, wr_yj;
  logic signed [32:0] dx, dy;
  logic signed [34:0] dlen;
  logic [35:0] rem2, trial;
  logic [34:0] dtry;
  logic [53:0] mu_raw;

  assign addr_i = AW'(ii_q);
  assign addr_j = AW'(jj_q);
  assign i_ok   = 32'(ii_q) < MAX_POINTS;
  assign j_ok   = 32'(jj_q) < MAX_POINTS;

  assign sts_o.action   = act_q;
  assign sts_o.i_ok     = i_ok;
  assign sts_o.j_ok     = j_ok;
  assign sts_o.len_zero = (root_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // one shared multiplier, result registered
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_MUL_XX:  begin mul_a = 34'(ax_q);          mul_b = 34'(ax_q);   end
      OP_MUL_YY:  begin mul_a = 34'(ay_q);          mul_b = 34'(ay_q);   end
      OP_MUL_SW:  begin mul_a = 34'(step_rate_i);   mul_b = 34'(w_q);    end
      OP_MUL_NUM: begin mul_a = 34'(mu_q);          mul_b = dmag_q;      end
      OP_MUL_RXL: begin mul_a = 34'(dvd_q[31:0]);   mul_b = 34'(ax_q);   end
      OP_MUL_RXH: begin mul_a = 34'(dvd_q[63:32]);  mul_b = 34'(ax_q);   end
      OP_MUL_RYL: begin mul_a = 34'(dvd_q[31:0]);   mul_b = 34'(ay_q);   end
      OP_MUL_RYH: begin mul_a = 34'(dvd_q[63:32]);  mul_b = 34'(ay_q);   end
      default:    mul_en = 1'b0;
    endcase
  end

  // point memory, {y, x}
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_WR_IN: mem[addr_i] <= {yin_q, xin_q};
      OP_RD_I:  rdata_q <= mem[addr_i];
      OP_RD_J:  rdata_q <= mem[addr_j];
      OP_WR_I:  mem[addr_i] <= {wr_yi, wr_xi};
      OP_WR_J:  mem[addr_j] <= {wr_yj, wr_xj};
      default: ;
    endcase
  end

  always_comb begin
    vx = (rneg_q ^ dxn_q) ? -$signed({1'b0, mx_q}) : $signed({1'b0, mx_q});
    vy = (rneg_q ^ dyn_q) ? -$signed({1'b0, my_q}) : $signed({1'b0, my_q});
    wr_xi = sat32($signed({{5{xi_q[31]}}, xi_q}) - $signed({vx[35], vx}));
    wr_yi = sat32($signed({{5{yi_q[31]}}, yi_q}) - $signed({vy[35], vy}));
    wr_xj = sat32($signed({{5{xj_q[31]}}, xj_q}) + $signed({vx[35], vx}));
    wr_yj = sat32($signed({{5{yj_q[31]}}, yj_q}) + $signed({vy[35], vy}));
    dx    = $signed({xi_q[31], xi_q}) - $signed({xj_q[31], xj_q});
    dy    = $signed({yi_q[31], yi_q}) - $signed({yj_q[31], yj_q});
    dlen  = $signed({2'b00, root_q}) - $signed({3'b000, t_q});
    rem2  = {sq_rem_q[33:0], rad_q[65:64]};
    trial = {1'b0, root_q, 2'b01};
    dtry  = {drem_q, dvd_q[63]};
    mu_raw = prod_q[63:10];
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        act_q <= spu_act_e'(in_user_i);
        ii_q  <= in_data_i[9:0];
        jj_q  <= in_data_i[19:10];
        w_q   <= in_data_i[51:20];
        t_q   <= in_data_i[83:52];
        xin_q <= in_data_i[115:84];
        yin_q <= in_data_i[147:116];
      end
      OP_RD_J: begin
        xi_q <= rdata_q[31:0];
        yi_q <= rdata_q[63:32];
      end
      OP_CAP_J: begin
        xj_q <= rdata_q[31:0];
        yj_q <= rdata_q[63:32];
      end
      OP_DIFF: begin
        dxn_q <= dx[32];
        dyn_q <= dy[32];
        ax_q  <= dx[32] ? 32'(-dx) : dx[31:0];
        ay_q  <= dy[32] ? 32'(-dy) : dy[31:0];
      end
      OP_MUL_YY: sx_q <= prod_q[63:0];
      OP_SUM: begin
        rad_q    <= 66'(sx_q) + 66'(prod_q[63:0]);
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      OP_SQRT: begin
        // one result bit per cycle
        rad_q <= {rad_q[63:0], 2'b00};
        if (rem2 >= trial) begin
          sq_rem_q <= rem2 - trial;
          root_q   <= {root_q[31:0], 1'b1};
        end else begin
          sq_rem_q <= rem2;
          root_q   <= {root_q[31:0], 1'b0};
        end
      end
      OP_MUL_SW: begin
        rneg_q <= dlen[34];
        dmag_q <= dlen[34] ? 34'(-dlen) : dlen[33:0];
      end
      OP_MU: mu_q <= (mu_raw > 54'(OneQ30)) ? OneQ30 : mu_raw[30:0];
      OP_DIV_INIT: begin
        dvd_q  <= prod_q[63:0];
        drem_q <= '0;
        dvs_q  <= {root_q, 1'b0};
      end
      OP_DIV: begin
        // restoring divide, quotient shifts into dvd_q
        if (dtry >= {1'b0, dvs_q}) begin
          drem_q <= 34'(dtry - {1'b0, dvs_q});
          dvd_q  <= {dvd_q[62:0], 1'b1};
        end else begin
          drem_q <= dtry[33:0];
          dvd_q  <= {dvd_q[62:0], 1'b0};
        end
      end
      OP_MUL_RXH: lo_q <= prod_q[63:0];
      OP_MUL_RYL: mx_q <= move_cap(prod_q[63:0], lo_q);
      OP_MUL_RYH: lo_q <= prod_q[63:0];
      OP_MVY:     my_q <= move_cap(prod_q[63:0], lo_q);
      OP_OUT: begin
        out_data_q <= {6'b0, (i_ok ? rdata_q[63:32] : 32'h0),
                       (i_ok ? rdata_q[31:0] : 32'h0), ii_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

@@ rtl/sgd_stress_pair_update.sv @@
// Stress-SGD layout engine: a table of MAX_POINTS points (x, y in signed
// Q16.16) with write, read-back and pair update items. One item is worked on
// at a time. A read waits for the output register while it is still full. An
// out-of-range pair ends after decoding, a zero-length pair after the 33-step
// bit-serial square root, and a full pair update also runs the 64-step
// bit-serial divider. The step_rate register (Q8.24) at byte address 0 must
// only be written while the block is idle. The point table has no reset; read
// only entries that have been written.
module sgd_stress_pair_update #(
  parameter int MAX_POINTS = spu_pkg::DefMaxPoints
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // index_i, index_j, weight, target_dist, x_in, y_in, zero pad
  input  logic [spu_pkg::InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // point_index, x_out, y_out, zero pad
  output logic [spu_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import spu_pkg::*;

  spu_cmd_t    cmd;
  spu_sts_t    sts;
  logic [31:0] step_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? step_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepRateReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      step_q <= pwdata;
    end
  end

  spu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spu_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .step_rate_i (step_q),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
